@@ rtl/bba_pkg.sv @@
// Shared types, constants and helper functions for the bitmap block allocator.
// Used by bba_map_ram and bitmap_block_allocator_unit; depends on nothing else.
`default_nettype none
package bba_pkg;

  // Store geometry.
  localparam int BLOCKS    = 65536;
  localparam int MAP_BYTES = (BLOCKS + 7) / 8;
  localparam int ADDR_W    = $clog2(MAP_BYTES);
  localparam int HINT_W    = ADDR_W + 1;

  // Map byte constants.
  localparam logic [7:0] BYTE_ALL_FREE = 8'hFF;
  localparam logic [7:0] RESERVED_MASK = 8'hC0;
  localparam logic [7:0] FIRST_BIT     = 8'h80;

  // Bits past the last block in a partial last byte stay used.
  localparam int         LAST_BITS = BLOCKS % 8;
  localparam logic [7:0] LAST_BYTE = (LAST_BITS == 0) ? BYTE_ALL_FREE :
                                     8'(BYTE_ALL_FREE << (8 - LAST_BITS));

  // Command codes.
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // Result status codes.
  localparam logic [1:0] ST_ALLOC = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_FREED = 2'd2;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_FREE,
    S_OUT
  } state_t;

  // One access to the map memory per cycle on each port.
  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
  } map_req_t;

  // Content of a map byte after reset.
  function automatic logic [7:0] init_byte(input logic [ADDR_W-1:0] addr);
    logic [7:0] val;
    val = BYTE_ALL_FREE;
    if (addr == ADDR_W'(MAP_BYTES - 1)) begin
      val = LAST_BYTE;
    end
    if (addr == '0) begin
      val = val & ~RESERVED_MASK;
    end
    return val;
  endfunction

  // Position of the first set bit counted from the MSB; 7 when none is set.
  function automatic logic [2:0] first_set(input logic [7:0] v);
    logic [2:0] pos;
    pos = 3'd7;
    for (int i = 6; i >= 0; i--) begin
      if (v[7-i]) begin
        pos = 3'(i);
      end
    end
    return pos;
  endfunction

endpackage
`default_nettype wire

@@ rtl/bba_map_ram.sv @@
// Free map storage: one byte per eight blocks, one write and one read port.
// Depends on bba_pkg for the geometry and the request struct.
`default_nettype none
module bba_map_ram (
  input  wire logic               clk,
  input  wire bba_pkg::map_req_t  req,
  output logic [7:0]              rd_data
);
  import bba_pkg::*;

  logic [7:0] mem [MAP_BYTES];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule
`default_nettype wire

@@ rtl/bitmap_block_allocator_unit.sv @@
// Top level of the first-fit bitmap block allocator.
// Depends on bba_pkg and bba_map_ram.
//
//   Channel   Direction  Ports                                 Handshake
//   request   in         in_cmd, in_block                      in_valid / in_stall
//   result    out        out_result_block, out_status          out_valid / out_stall
//
// After reset the map is initialized by a clearing pass that writes one byte per
// cycle over all MAP_BYTES map bytes (8192 for 65536 blocks); requests are stalled meanwhile.
// An allocate reads the map memory one byte per cycle, starting from the lowest
// byte that may hold a free block, until a byte with a free bit or the end of
// the map is reached. A free reads, modifies and writes back one map byte. One
// request is in work at a time; the result register lets a new request be taken
// while the previous result still waits on a stalled output.
`default_nettype none
module bitmap_block_allocator_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_cmd,
  input  wire logic [15:0] in_block,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      out_result_block,
  output logic [1:0]       out_status
);
  import bba_pkg::*;

  state_t              state_r, state_nxt;
  logic [ADDR_W-1:0]   clr_ptr_r, clr_ptr_nxt;
  // The hint is the lowest byte that may still hold a free block; MAP_BYTES means full.
  logic [HINT_W-1:0]   hint_r, hint_nxt;
  logic [HINT_W-1:0]   ptr_r, ptr_nxt;
  logic [ADDR_W-1:0]   chk_r, chk_nxt;
  logic [15:0]         blk_r, blk_nxt;
  logic [15:0]         res_block_r, res_block_nxt;
  logic [1:0]          res_status_r, res_status_nxt;
  logic                out_valid_r;
  logic [15:0]         out_block_r;
  logic [1:0]          out_status_r;

  map_req_t            map_req;
  logic [7:0]          rd_data;

  logic                in_acc;
  logic                out_free;
  logic                out_load;
  logic                hint_full;
  logic                in_range;
  logic [31:0]         in_byte_wide;
  logic [ADDR_W-1:0]   in_byte;
  logic [ADDR_W-1:0]   blk_byte;
  logic                scan_hit;
  logic                scan_end;
  logic [2:0]          hit_pos;
  logic [31:0]         hit_idx;

  bba_map_ram u_map (
    .clk     (clk),
    .req     (map_req),
    .rd_data (rd_data)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign hint_full = (hint_r == HINT_W'(MAP_BYTES));

  // Frees of blocks past the end of the store only echo the index.
  assign in_range     = (32'(in_block) < 32'(BLOCKS));
  assign in_byte_wide = 32'(in_block) >> 3;
  assign in_byte      = in_byte_wide[ADDR_W-1:0];
  assign blk_byte     = ADDR_W'(32'(blk_r) >> 3);

  // The byte read last cycle belongs to chk_r; any set bit ends the scan.
  assign scan_hit = (rd_data != 8'h00);
  assign scan_end = (ptr_r == HINT_W'(MAP_BYTES));
  assign hit_pos  = first_set(rd_data);
  assign hit_idx  = (32'(chk_r) << 3) | 32'(hit_pos);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (clr_ptr_r == ADDR_W'(MAP_BYTES - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          if (in_cmd == CMD_ALLOC) begin
            state_nxt = hint_full ? S_OUT : S_SCAN;
          end else begin
            state_nxt = in_range ? S_FREE : S_OUT;
          end
        end
      end
      S_SCAN: begin
        if (scan_hit || scan_end) begin
          state_nxt = S_OUT;
        end
      end
      S_FREE: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  // Memory requests and datapath updates.
  always_comb begin
    map_req        = '0;
    clr_ptr_nxt    = clr_ptr_r;
    hint_nxt       = hint_r;
    ptr_nxt        = ptr_r;
    chk_nxt        = chk_r;
    blk_nxt        = blk_r;
    res_block_nxt  = res_block_r;
    res_status_nxt = res_status_r;
    out_load       = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        map_req.wr_en   = 1'b1;
        map_req.wr_addr = clr_ptr_r;
        map_req.wr_data = init_byte(clr_ptr_r);
        clr_ptr_nxt     = clr_ptr_r + 1'b1;
      end
      S_IDLE: begin
        if (in_acc) begin
          if (in_cmd == CMD_ALLOC) begin
            if (hint_full) begin
              res_block_nxt  = 16'd0;
              res_status_nxt = ST_FULL;
            end else begin
              map_req.rd_en   = 1'b1;
              map_req.rd_addr = hint_r[ADDR_W-1:0];
              chk_nxt         = hint_r[ADDR_W-1:0];
              ptr_nxt         = hint_r + 1'b1;
            end
          end else begin
            blk_nxt        = in_block;
            res_block_nxt  = in_block;
            res_status_nxt = ST_FREED;
            if (in_range) begin
              map_req.rd_en   = 1'b1;
              map_req.rd_addr = in_byte;
              if ({1'b0, in_byte} < hint_r) begin
                hint_nxt = {1'b0, in_byte};
              end
            end
          end
        end
      end
      S_SCAN: begin
        if (scan_hit) begin
          map_req.wr_en   = 1'b1;
          map_req.wr_addr = chk_r;
          map_req.wr_data = rd_data & ~(FIRST_BIT >> hit_pos);
          res_block_nxt   = hit_idx[15:0];
          res_status_nxt  = ST_ALLOC;
          hint_nxt        = {1'b0, chk_r};
        end else if (scan_end) begin
          res_block_nxt  = 16'd0;
          res_status_nxt = ST_FULL;
          hint_nxt       = HINT_W'(MAP_BYTES);
        end else begin
          map_req.rd_en   = 1'b1;
          map_req.rd_addr = ptr_r[ADDR_W-1:0];
          chk_nxt         = ptr_r[ADDR_W-1:0];
          ptr_nxt         = ptr_r + 1'b1;
        end
      end
      S_FREE: begin
        map_req.wr_en   = 1'b1;
        map_req.wr_addr = blk_byte;
        map_req.wr_data = rd_data | (FIRST_BIT >> blk_r[2:0]);
      end
      S_OUT: begin
        out_load = out_free;
      end
      default: begin
        map_req = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_ptr_r <= '0;
      hint_r    <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_ptr_r <= clr_ptr_nxt;
      hint_r    <= hint_nxt;
    end
  end

  // Scan pointers and the pending result carry no reset.
  always_ff @(posedge clk) begin
    ptr_r        <= ptr_nxt;
    chk_r        <= chk_nxt;
    blk_r        <= blk_nxt;
    res_block_r  <= res_block_nxt;
    res_status_r <= res_status_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_block_r  <= res_block_r;
      out_status_r <= res_status_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_block = out_block_r;
  assign out_status       = out_status_r;

  // A request in work keeps the input stalled until its result is handed on.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> in_stall)
    else $error("request accepted while another one is in work");

  // The lowest-free hint never points past the end of the map.
  a_hint_range: assert property (@(posedge clk) disable iff (!rst_n)
    hint_r <= HINT_W'(MAP_BYTES))
    else $error("allocation hint out of range");

  // During a scan the next read address runs one byte ahead of the checked byte.
  a_scan_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (ptr_r == {1'b0, chk_r} + 1'b1))
    else $error("scan pointers out of step");

  // An allocated block always lies inside the store.
  a_alloc_in_store: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_ALLOC)) |-> (32'(out_result_block) < 32'(BLOCKS)))
    else $error("allocated block past the end of the store");

endmodule
`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for the first-fit bitmap block allocator.
// Depends on bba_pkg and bitmap_block_allocator_unit; it keeps its own copy of the map
// and compares every allocate and free reply against it.
`timescale 1ns / 100ps
module testbench;
  import bba_pkg::*;

  // One request as it crosses the input handshake, and one reply on the output.
  typedef struct packed {
    logic        cmd;
    logic [15:0] block;
  } request_t;

  typedef struct packed {
    logic [15:0] block;
    logic [1:0]  status;
  } reply_t;

  // The receiver's long hold-off, in cycles. It must be long enough for the
  // result register and the request in work to fill, so that in_stall rises.
  localparam int HOLD_LEN = 300;
  // Cycles with no handshake on either channel before the run is abandoned.
  // The clearing pass and a full-map scan each run over all MAP_BYTES map bytes.
  // The hold-off and the longest random gaps are far shorter than the limit.
  localparam int WATCHDOG_LIMIT = 40000;
  // Quiet cycles after the last reply.
  localparam int SETTLE_CYCLES = 20;
  localparam int MAX_PRINTS = 40;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_cmd = CMD_ALLOC;
  logic [15:0] in_block = 16'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] out_result_block;
  logic [1:0]  out_status;

  bitmap_block_allocator_unit uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_cmd           (in_cmd),
    .in_block         (in_block),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_block (out_result_block),
    .out_status       (out_status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Requests waiting to be offered, and replies the allocator still owes us.
  request_t request_queue[$];
  reply_t   awaited_replies[$];

  // Our own view of the free map. A set bit marks a free block, and the MSB of
  // each byte is the lowest block of that byte. scan_from is the lowest byte
  // that can still hold a free block, so a first-fit search never has to
  // start below it.
  logic [7:0] free_bits [MAP_BYTES];
  int         scan_from;

  int   mismatches = 0;
  bit   req_taken = 1'b0;
  int   idle_cycles = 0;
  bit   idle_en = 1'b0;
  int   send_gap = 0;
  // The stimulus raises hold_req; the stall process answers with hold_done.
  // A difference between the two asks for one long hold-off.
  int   hold_req = 0;
  int   hold_done = 0;
  int   hold_left = 0;
  int   stall_left = 0;
  int   run_left = 0;

  task automatic report_mismatch(input string msg);
    if (mismatches < MAX_PRINTS) begin
      $display("MISMATCH at %0t ns: %s", $time, msg);
    end
    mismatches++;
  endtask

  // Applies one accepted request to our map and returns the reply it must get.
  // An allocate takes the lowest free block, or reports full with block 0.
  // A free sets the block's bit (harmless if already free) and echoes the index.
  task automatic update_bitmap(input request_t req, output reply_t rep);
    int byte_idx;
    int bit_pos;
    rep.block  = 16'd0;
    rep.status = ST_FULL;
    if (req.cmd == CMD_ALLOC) begin
      byte_idx = scan_from;
      while (byte_idx < MAP_BYTES && free_bits[byte_idx] == 8'h00) begin
        byte_idx++;
      end
      scan_from = byte_idx;
      if (byte_idx < MAP_BYTES) begin
        bit_pos = 0;
        while (!free_bits[byte_idx][7 - bit_pos]) begin
          bit_pos++;
        end
        free_bits[byte_idx][7 - bit_pos] = 1'b0;
        rep.block  = 16'(byte_idx * 8 + bit_pos);
        rep.status = ST_ALLOC;
      end
    end else begin
      if (int'(req.block) < BLOCKS) begin
        byte_idx = int'(req.block) >> 3;
        bit_pos  = int'(req.block) & 7;
        free_bits[byte_idx][7 - bit_pos] = 1'b1;
        if (byte_idx < scan_from) begin
          scan_from = byte_idx;
        end
      end
      rep.block  = req.block;
      rep.status = ST_FREED;
    end
  endtask

  // Idle stretch length: mostly none, often a few cycles, now and then long.
  function automatic int idle_length();
    int r;
    if (!idle_en) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 65) begin
      return 0;
    end
    if (r < 93) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  // Random request mix. Most frees target the low blocks, where first fit has
  // been handing out blocks, so they usually release something really in use.
  // The rest range over the whole index space.
  function automatic request_t random_request();
    request_t req;
    int r;
    r = $urandom_range(0, 99);
    req.block = 16'($urandom_range(0, 65535));
    if (r < 55) begin
      req.cmd = CMD_ALLOC;
    end else if (r < 85) begin
      req.cmd   = CMD_FREE;
      req.block = 16'($urandom_range(0, 255));
    end else begin
      req.cmd = CMD_FREE;
    end
    return req;
  endfunction

  task automatic queue_request(input logic cmd, input logic [15:0] block);
    request_t req;
    req.cmd   = cmd;
    req.block = block;
    request_queue.push_back(req);
  endtask

  // Waits, without time limit of its own, until every queued request has
  // been accepted and every reply has come back. The watchdog guards it.
  task automatic drain();
    while (request_queue.size() != 0 || in_valid || awaited_replies.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // Request driver. It works on the falling edge, so the payload is stable
  // well before the rising edge that may accept it. A request stays on the
  // port, unchanged, until a rising edge sees valid high with stall low.
  always @(negedge clk) begin : drive_requests
    request_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || req_taken) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (request_queue.size() > 0) begin
        nxt = request_queue.pop_front();
        in_valid <= 1'b1;
        in_cmd   <= nxt.cmd;
        in_block <= nxt.block;
        send_gap <= idle_length();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Reply-side back-pressure. A requested hold-off takes priority. It keeps
  // out_stall high for the HOLD_LEN hold-off while the driver keeps offering, so
  // the allocator backs up and stalls its input. Otherwise short runs of
  // free flow alternate with random stalls from idle_length.
  always @(negedge clk) begin : drive_stall
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (hold_req != hold_done) begin
      hold_done <= hold_done + 1;
      hold_left <= HOLD_LEN - 1;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (run_left > 0) begin
      run_left  <= run_left - 1;
      out_stall <= 1'b0;
    end else begin
      out_stall  <= 1'b0;
      run_left   <= $urandom_range(0, 6);
      stall_left <= idle_length();
    end
  end

  // Rising-edge monitor. Each accepted request updates our map and queues
  // the reply it must produce. Each accepted reply is checked, field by
  // field, against the oldest reply still owed. The same block also keeps
  // the watchdog on cycles in which neither channel moves.
  always @(posedge clk) begin : check_replies
    request_t taken;
    reply_t   want;
    reply_t   seen;
    if (!rst_n) begin
      req_taken   <= 1'b0;
      idle_cycles <= 0;
    end else begin
      req_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        taken.cmd   = in_cmd;
        taken.block = in_block;
        update_bitmap(taken, want);
        awaited_replies.push_back(want);
      end
      if (out_valid && !out_stall) begin
        seen.block  = out_result_block;
        seen.status = out_status;
        if (awaited_replies.size() == 0) begin
          report_mismatch($sformatf("unexpected reply: block %0d status %0d",
                                    seen.block, seen.status));
        end else begin
          want = awaited_replies.pop_front();
          if (seen.block !== want.block) begin
            report_mismatch($sformatf("result_block %0d, expected %0d",
                                      seen.block, want.block));
          end
          if (seen.status !== want.status) begin
            report_mismatch($sformatf("status %0d, expected %0d (block %0d)",
                                      seen.status, want.status, want.block));
          end
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    int b;
    // Our map after reset: all free but blocks 0 and 1. Any bits past the
    // last block in a partial final byte are held used.
    for (b = 0; b < MAP_BYTES; b++) begin
      free_bits[b] = 8'hFF;
    end
    free_bits[0] = 8'h3F;
    for (b = BLOCKS; b < MAP_BYTES * 8; b++) begin
      free_bits[b >> 3][7 - (b & 7)] = 1'b0;
    end
    scan_from = 0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part, no idling. The first allocates skip the two reserved
    // blocks. Blocks 0 and 1 are then freed and handed out again, and a block
    // that is already free is freed twice. The highest index is freed. A run
    // of allocates crosses into the second map byte, and holes left by frees
    // are refilled lowest first. The block field is ignored on allocate, so
    // the first allocates carry both all-zero and all-one values.
    queue_request(CMD_ALLOC, 16'h0000);
    queue_request(CMD_ALLOC, 16'hFFFF);
    queue_request(CMD_FREE,  16'd0);
    queue_request(CMD_ALLOC, 16'h5A5A);
    queue_request(CMD_FREE,  16'd1);
    queue_request(CMD_FREE,  16'd1);
    queue_request(CMD_ALLOC, 16'd0);
    queue_request(CMD_FREE,  16'hFFFF);
    queue_request(CMD_FREE,  16'd500);
    repeat (6) queue_request(CMD_ALLOC, 16'($urandom_range(0, 65535)));
    queue_request(CMD_FREE,  16'd3);
    queue_request(CMD_FREE,  16'd8);
    queue_request(CMD_ALLOC, 16'd0);
    queue_request(CMD_ALLOC, 16'd0);
    queue_request(CMD_ALLOC, 16'd0);
    queue_request(CMD_FREE,  16'd10);
    drain();

    // Random mix with idling on both sides.
    idle_en = 1'b1;
    repeat (40) request_queue.push_back(random_request());
    drain();

    // Long receiver hold-off while the driver keeps offering back to back.
    // The drain that follows is the sender's pause, which lasts until every
    // reply is home.
    idle_en = 1'b0;
    hold_req = hold_req + 1;
    repeat (12) request_queue.push_back(random_request());
    drain();

    // Free a few scattered blocks, including the last block and block 2,
    // then allocate again so the lowest holes are taken first.
    queue_request(CMD_FREE, 16'hFFFF);
    queue_request(CMD_FREE, 16'd40000);
    queue_request(CMD_FREE, 16'd2);
    queue_request(CMD_FREE, 16'($urandom_range(3, 65534)));
    repeat (5) queue_request(CMD_ALLOC, 16'($urandom_range(0, 65535)));
    drain();

    // A last random stretch.
    idle_en = 1'b1;
    repeat (20) request_queue.push_back(random_request());
    drain();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && awaited_replies.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
